// ===== design/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpc_pkg: gear position classifier shared definitions
// Constants, field types and the lane control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package gpc_pkg;

  localparam int NUM_GEARS       = 8;
  localparam int NUM_AXES        = 3;
  localparam int CAPTURE_SAMPLES = 5;

  localparam int AXIS_W      = 16;
  localparam int TOL_W       = 10;
  localparam int GEAR_OUT_W  = 3;
  localparam int FRAME_OUT_W = 4;

  localparam int GEAR_W  = $clog2(NUM_GEARS);
  localparam int FRAME_W = $clog2(NUM_GEARS + 1);
  localparam int CAP_W   = $clog2(CAPTURE_SAMPLES + 1);

  localparam logic [FRAME_W-1:0] DISPLAY_FRAME = FRAME_W'(NUM_GEARS);
  localparam logic [TOL_W-1:0]   TOL_RESET     = TOL_W'(50);

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic [TOL_W-1:0]         tol_t;
  typedef logic [GEAR_OUT_W-1:0]    gear_t;
  typedef logic [FRAME_OUT_W-1:0]   frame_t;

  // unwritten table entries read as -1
  localparam axis_t REF_RESET = '1;

  typedef struct packed {
    logic              load;        // latch the new sample
    logic              capture;     // fold the sample into min/max
    logic              write;       // write midpoint, clear min/max
    logic              range_valid; // min/max already hold a sample
    logic              ref_valid;   // addressed entry has been written
    logic [GEAR_W-1:0] gear_idx;    // read / write address
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== design/gpc_if.sv =====
// ----------------------------------------------------------------------------
// gpc_in_if / gpc_out_if: item channels of the gear classifier
// Valid/ready channels carrying a sample item and a result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpc_in_if;
  import gpc_pkg::*;

  logic  valid;
  logic  ready;
  axis_t sample_x;
  axis_t sample_y;
  axis_t sample_z;
  logic  sensor_ok;
  logic  key_down;

  modport source (output valid, sample_x, sample_y, sample_z, sensor_ok, key_down,
                  input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, sensor_ok, key_down,
                  output ready);
endinterface

interface gpc_out_if;
  import gpc_pkg::*;

  logic   valid;
  logic   ready;
  gear_t  gear;
  logic   gear_changed;
  frame_t frame;
  logic   capturing;
  logic   entry_written;
  logic   config_saved;

  modport source (output valid, gear, gear_changed, frame, capturing, entry_written,
                  config_saved, input ready);
  modport sink   (input valid, gear, gear_changed, frame, capturing, entry_written,
                  config_saved, output ready);
endinterface

`default_nettype wire

// ===== design/gpc_lane.sv =====
// ----------------------------------------------------------------------------
// gpc_lane: one axis lane
// Holds the axis column of the reference table, tests the sample against
// the addressed entry and tracks min/max while calibrating.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_lane (
  input  wire logic              clk,
  input  gpc_pkg::lane_ctl_t     ctl,
  input  gpc_pkg::axis_t         sample_in,
  input  gpc_pkg::tol_t          tol,
  output logic                   match
);
  import gpc_pkg::*;

  axis_t samp_r;
  axis_t min_r;
  axis_t max_r;
  axis_t ref_mem_r [NUM_GEARS];

  axis_t                   ref_rd;
  axis_t                   min_nxt;
  axis_t                   max_nxt;
  axis_t                   mid;
  logic signed [AXIS_W:0]  diff;
  logic [AXIS_W:0]         mag;
  logic [AXIS_W:0]         sum;
  logic [AXIS_W:0]         adj;

  always_comb begin
    ref_rd = ctl.ref_valid ? ref_mem_r[ctl.gear_idx] : REF_RESET;
    diff   = {ref_rd[AXIS_W-1], ref_rd} - {samp_r[AXIS_W-1], samp_r};
    mag    = diff[AXIS_W] ? (AXIS_W+1)'(-diff) : (AXIS_W+1)'(diff);
    match  = (mag <= (AXIS_W+1)'(tol));
  end

  always_comb begin
    min_nxt = (!ctl.range_valid || (samp_r < min_r)) ? samp_r : min_r;
    max_nxt = (!ctl.range_valid || (samp_r > max_r)) ? samp_r : max_r;
    sum     = {min_nxt[AXIS_W-1], min_nxt} + {max_nxt[AXIS_W-1], max_nxt};
    // halve toward zero: bump negative sums by one before the shift
    adj     = sum + {{AXIS_W{1'b0}}, sum[AXIS_W]};
    mid     = adj[AXIS_W:1];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      samp_r <= sample_in;
    end
    if (ctl.capture) begin
      if (ctl.write) begin
        ref_mem_r[ctl.gear_idx] <= mid;
        min_r <= '0;
        max_r <= '0;
      end else begin
        min_r <= min_nxt;
        max_r <= max_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/gear_position_classifier_calibrator.sv =====
// ----------------------------------------------------------------------------
// gear_position_classifier_calibrator: magnetic gear classifier
// An accepted item runs the gear scan (display frames only), then the finish state,
//   which loads the result register; no new item is taken before that. The scan
//   tests one gear per cycle across all axis lanes, stopping at the first match.
// The result register lets a new item in while a result waits downstream.
// Reset (rst_n low, synchronous): display frame, tolerance 50, no capture,
//   all table entries read as -1 until calibrated.
// ----------------------------------------------------------------------------
`default_nettype none

module gear_position_classifier_calibrator (
  input  wire logic                clk,
  input  wire logic                rst_n,
  gpc_in_if.sink                   in_ch,
  gpc_out_if.source                out_ch,
  input  wire logic                cfg_we,
  input  wire gpc_pkg::tol_t       cfg_wdata
);
  import gpc_pkg::*;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [GEAR_W-1:0]  gidx_r, gidx_nxt;     // gear under test
  logic [GEAR_W-1:0]  res_gear_r, res_gear_nxt;
  logic               key_r;
  tol_t               tol_r;

  // block state
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic [FRAME_W-1:0] pend_frame_r, pend_frame_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [GEAR_W-1:0]  last_gear_r, last_gear_nxt;
  logic               lg_valid_r, lg_valid_nxt;
  logic [CAP_W-1:0]   cap_cnt_r, cap_cnt_nxt;
  logic               range_valid_r, range_valid_nxt;
  logic [NUM_GEARS-1:0] ref_vld_r, ref_vld_nxt;

  // result register
  logic               out_valid_r;
  gear_t              out_gear_r;
  logic               out_changed_r, changed;
  frame_t             out_frame_r;
  logic               out_capt_r, capt;
  logic               out_written_r, written;
  logic               out_saved_r, saved;

  logic               in_acc;
  logic               fin_go;
  logic               took;
  logic               all_match;
  lane_ctl_t          lane_ctl;
  axis_t              lane_samp [NUM_AXES];
  logic [NUM_AXES-1:0] lane_match;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign fin_go      = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign took        = (cap_cnt_r != '0);
  assign all_match   = &lane_match;

  // ---- axis lanes ----------------------------------------------------------
  always_comb begin
    lane_ctl.load        = in_acc;
    lane_ctl.capture     = fin_go && took;
    lane_ctl.write       = fin_go && (cap_cnt_r == CAP_W'(1));
    lane_ctl.range_valid = range_valid_r;
    // scan reads the gear under test; capture writes the current frame
    lane_ctl.gear_idx    = (state_r == ST_SCAN) ? gidx_r : frame_r[GEAR_W-1:0];
    lane_ctl.ref_valid   = ref_vld_r[lane_ctl.gear_idx];
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    if (a == 0) begin : g_x
      assign lane_samp[a] = in_ch.sample_x;
    end else if (a == 1) begin : g_y
      assign lane_samp[a] = in_ch.sample_y;
    end else if (a == 2) begin : g_z
      assign lane_samp[a] = in_ch.sample_z;
    end else begin : g_zero
      // axes past the third see a zero sample
      assign lane_samp[a] = '0;
    end

    gpc_lane u_lane (
      .clk       (clk),
      .ctl       (lane_ctl),
      .sample_in (lane_samp[a]),
      .tol       (tol_r),
      .match     (lane_match[a])
    );
  end

  // ---- sequencer and merge -------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    gidx_nxt     = gidx_r;
    res_gear_nxt = res_gear_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          gidx_nxt     = GEAR_W'(1);
          res_gear_nxt = '0;
          // classify only in display, outside capture, on a good read
          if (!took && (frame_r == DISPLAY_FRAME) && in_ch.sensor_ok) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        if (all_match) begin
          res_gear_nxt = gidx_r;
          state_nxt    = ST_FIN;
        end else if (gidx_r == GEAR_W'(NUM_GEARS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          gidx_nxt = gidx_r + GEAR_W'(1);
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---- state update at item end --------------------------------------------
  always_comb begin
    frame_nxt       = frame_r;
    pend_frame_nxt  = pend_frame_r;
    pend_valid_nxt  = pend_valid_r;
    last_gear_nxt   = last_gear_r;
    lg_valid_nxt    = lg_valid_r;
    cap_cnt_nxt     = cap_cnt_r;
    range_valid_nxt = range_valid_r;
    ref_vld_nxt     = ref_vld_r;
    changed         = 1'b0;
    written         = 1'b0;
    saved           = 1'b0;
    if (took) begin
      // calibration sample; key is ignored until the capture ends
      range_valid_nxt = 1'b1;
      cap_cnt_nxt     = cap_cnt_r - CAP_W'(1);
      if (cap_cnt_r == CAP_W'(1)) begin
        ref_vld_nxt[frame_r[GEAR_W-1:0]] = 1'b1;
        range_valid_nxt = 1'b0;
        written         = 1'b1;
        frame_nxt       = pend_frame_r;
        pend_valid_nxt  = 1'b0;
        saved           = (pend_frame_r == DISPLAY_FRAME);
      end
    end else begin
      if (frame_r == DISPLAY_FRAME) begin
        changed       = !lg_valid_r || (res_gear_r != last_gear_r);
        last_gear_nxt = res_gear_r;
        lg_valid_nxt  = 1'b1;
      end
      if (key_r) begin
        pend_frame_nxt = (frame_r != DISPLAY_FRAME) ? frame_r + FRAME_W'(1) : '0;
        pend_valid_nxt = 1'b1;
      end else if (pend_valid_r) begin
        if (frame_r != DISPLAY_FRAME) begin
          cap_cnt_nxt     = CAP_W'(CAPTURE_SAMPLES);
          range_valid_nxt = 1'b0;
        end else begin
          frame_nxt      = pend_frame_r;
          pend_valid_nxt = 1'b0;
          saved          = (pend_frame_r == DISPLAY_FRAME);
        end
      end
    end
    capt = took || (cap_cnt_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      tol_r         <= TOL_RESET;
      frame_r       <= DISPLAY_FRAME;
      pend_frame_r  <= '0;
      pend_valid_r  <= 1'b0;
      last_gear_r   <= '0;
      lg_valid_r    <= 1'b0;
      cap_cnt_r     <= '0;
      range_valid_r <= 1'b0;
      ref_vld_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
      if (fin_go) begin
        frame_r       <= frame_nxt;
        pend_frame_r  <= pend_frame_nxt;
        pend_valid_r  <= pend_valid_nxt;
        last_gear_r   <= last_gear_nxt;
        lg_valid_r    <= lg_valid_nxt;
        cap_cnt_r     <= cap_cnt_nxt;
        range_valid_r <= range_valid_nxt;
        ref_vld_r     <= ref_vld_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    gidx_r     <= gidx_nxt;
    res_gear_r <= res_gear_nxt;
    if (in_acc) begin
      key_r <= in_ch.key_down;
    end
    if (fin_go) begin
      out_gear_r    <= GEAR_OUT_W'(last_gear_nxt);
      out_changed_r <= changed;
      out_frame_r   <= FRAME_OUT_W'(frame_nxt);
      out_capt_r    <= capt;
      out_written_r <= written;
      out_saved_r   <= saved;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.gear          = out_gear_r;
  assign out_ch.gear_changed  = out_changed_r;
  assign out_ch.frame         = out_frame_r;
  assign out_ch.capturing     = out_capt_r;
  assign out_ch.entry_written = out_written_r;
  assign out_ch.config_saved  = out_saved_r;

  // ---- checks --------------------------------------------------------------
  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    cap_cnt_r <= CAP_W'(CAPTURE_SAMPLES))
    else $error("capture count out of range");

  a_cap_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_cnt_r != '0) |-> (frame_r != DISPLAY_FRAME) && pend_valid_r)
    else $error("capture running outside a calibration frame");

  a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_r <= DISPLAY_FRAME)
    else $error("frame beyond display");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside item end");

  a_saved_display: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_saved_r) |-> (out_frame_r == FRAME_OUT_W'(NUM_GEARS)))
    else $error("save flagged outside display");

endmodule

`default_nettype wire
